// ===== src/uttf_pkg.sv =====
// shared types, constants and enums for the underrun tail fade pad
package uttf_pkg;

    localparam int FRAMES = 8192;
    localparam int RAMP   = 64;

    localparam int SMP_W  = 16;
    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int REAL_W = $clog2(FRAMES + 1);
    localparam int NUM_W  = (RAMP > 1) ? $clog2(RAMP) : 1;
    localparam int LEN_W  = $clog2(RAMP + 1);
    localparam int MAG_W  = SMP_W + NUM_W;
    localparam int CNT_W  = $clog2(MAG_W);
    localparam int UCNT_W = 32;

    typedef struct packed {
        logic                    slot_present;
        logic signed [SMP_W-1:0] left_sample;
        logic signed [SMP_W-1:0] right_sample;
    } t_in;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic [UCNT_W-1:0]       underrun_count;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// ===== src/underrun_tail_fade_pad.sv =====
// top level of the underrun tail fade pad
// usage:
//   input channel i_in / i_in_valid / o_in_stall carries one buffer slot per item:
//   a present flag and a left/right pcm frame. output channel o_out / o_out_valid /
//   i_out_stall returns exactly one frame per input item, the frame leaving the
//   RAMP-deep delay line, faded if it sits in the tail of a short buffer, and the
//   running underrun count. mono_mode is written with i_cfg_we / i_cfg_wdata
//   while the block is idle: a rule for the user, not enforced by the block.
// timing:
//   an item is accepted only while the controller is idle. it then passes S_MUL,
//   forming sample times numerator, S_DIV, the restoring divide of the MAG_W-bit
//   (22 at RAMP = 64) magnitude by the fade length, and S_OUT, loading the output
//   register. a new item is accepted only after that load, once idle again.
// reset:
//   synchronous active low reset clears the delay line and tags to zero, the
//   slot and frame counters, the underrun count and mono_mode.
// stall:
//   a result waits in the output register while i_out_stall is high; the next
//   item can still be accepted and computed, and waits before the load.
module underrun_tail_fade_pad
    import uttf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  t_in  i_in,
    input  logic i_in_valid,
    output logic o_in_stall,
    output t_out o_out,
    output logic o_out_valid,
    input  logic i_out_stall
);

    // command and status between controller and datapath
    t_cmd    w_cmd;
    t_status w_status;

    uttf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    uttf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .o_status    (w_status)
    );

endmodule

// ===== src/uttf_ctrl.sv =====
// controller state machine sequencing accept, multiply, divide and output load
module uttf_ctrl
    import uttf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL;
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_MUL: o_cmd.mul = 1'b1;
            S_DIV: o_cmd.step = 1'b1;
            S_OUT: o_cmd.load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    // divide runs until its last step
    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_status.div_last) |=> (r_state == S_DIV))
        else $error("divide left early");

    // a result is loaded only when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_status.out_free)
        else $error("output overwritten");

    // after an accept the multiply follows
    a_acc_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_MUL))
        else $error("accept not followed by multiply");

endmodule

// ===== src/uttf_dp.sv =====
// datapath: delay line with fade tags, buffer counters, gain divide, output register
module uttf_dp
    import uttf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  t_in     i_in,
    input  t_cmd    i_cmd,
    input  logic    i_out_stall,
    output t_out    o_out,
    output logic    o_out_valid,
    output t_status o_status
);

    logic                    r_mono;
    logic [2*SMP_W-1:0]      r_dly [RAMP];
    logic [NUM_W-1:0]        r_num [RAMP];
    logic [LEN_W-1:0]        r_len [RAMP];
    logic [SLOT_W-1:0]       r_slot;
    logic [REAL_W-1:0]       r_real;
    logic                    r_short;
    logic [UCNT_W-1:0]       r_under;

    logic signed [SMP_W-1:0] r_xl, r_xr;
    logic [NUM_W-1:0]        r_xnum;
    logic [LEN_W-1:0]        r_xlen;

    logic [MAG_W-1:0]        r_ql, r_qr;
    logic [LEN_W-1:0]        r_reml, r_remr;
    logic                    r_negl, r_negr;
    logic [LEN_W-1:0]        r_dvs;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    t_out                    r_out;

    logic [SMP_W-1:0]        w_r;
    logic                    w_take, w_tag;
    logic [LEN_W-1:0]        w_ramp;
    logic [NUM_W-1:0]        w_tnum [RAMP];
    logic [LEN_W-1:0]        w_tlen [RAMP];
    logic [NUM_W-1:0]        w_mnum;
    logic [LEN_W-1:0]        w_mlen;
    logic signed [MAG_W:0]   w_pl, w_pr;
    logic [LEN_W+MAG_W-1:0]  w_dl, w_dr;
    logic [MAG_W-1:0]        w_nl, w_nr;

    function automatic logic [LEN_W+MAG_W-1:0] div_step(
        input logic [LEN_W-1:0] rem,
        input logic [MAG_W-1:0] q,
        input logic [LEN_W-1:0] dvs
    );
        logic [LEN_W:0] t;
        logic           b;
        t = {rem, q[MAG_W-1]};
        b = (t >= {1'b0, dvs});
        if (b) t = t - {1'b0, dvs};
        return {t[LEN_W-1:0], q[MAG_W-2:0], b};
    endfunction

    assign w_r    = r_mono ? i_in.left_sample : i_in.right_sample;
    assign w_take = i_in.slot_present && !r_short;
    assign w_tag  = !i_in.slot_present && !r_short;
    assign w_ramp = (r_real < REAL_W'(RAMP)) ? LEN_W'(r_real) : LEN_W'(RAMP);

    // tags applied before the exiting entry is read
    always_comb begin
        for (int j = 0; j < RAMP; j++) begin
            if (w_tag && (LEN_W'(j) < w_ramp)) begin
                w_tnum[j] = NUM_W'(j);
                w_tlen[j] = w_ramp;
            end else begin
                w_tnum[j] = r_num[j];
                w_tlen[j] = r_len[j];
            end
        end
    end

    // untagged entries pass as gain 1/1
    assign w_mnum = (r_xlen == '0) ? NUM_W'(1) : r_xnum;
    assign w_mlen = (r_xlen == '0) ? LEN_W'(1) : r_xlen;
    assign w_pl   = r_xl * $signed({1'b0, w_mnum});
    assign w_pr   = r_xr * $signed({1'b0, w_mnum});
    assign w_dl   = div_step(r_reml, r_ql, r_dvs);
    assign w_dr   = div_step(r_remr, r_qr, r_dvs);
    assign w_nl   = r_negl ? (MAG_W'(0) - r_ql) : r_ql;
    assign w_nr   = r_negr ? (MAG_W'(0) - r_qr) : r_qr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono  <= 1'b0;
            r_slot  <= '0;
            r_real  <= '0;
            r_short <= 1'b0;
            r_under <= '0;
            for (int j = 0; j < RAMP; j++) begin
                r_dly[j] <= '0;
                r_num[j] <= '0;
                r_len[j] <= '0;
            end
        end else begin
            if (i_cfg_we) r_mono <= i_cfg_wdata;
            if (i_cmd.accept) begin
                for (int j = 1; j < RAMP; j++) begin
                    r_dly[j] <= r_dly[j-1];
                    r_num[j] <= w_tnum[j-1];
                    r_len[j] <= w_tlen[j-1];
                end
                r_dly[0] <= w_take ? {w_r, i_in.left_sample} : '0;
                r_num[0] <= '0;
                r_len[0] <= '0;
                if (w_tag) r_under <= r_under + UCNT_W'(1);
                if (r_slot == SLOT_W'(FRAMES - 1)) begin
                    r_slot  <= '0;
                    r_real  <= '0;
                    r_short <= 1'b0;
                end else begin
                    r_slot  <= r_slot + SLOT_W'(1);
                    r_real  <= r_real + REAL_W'(w_take);
                    r_short <= r_short | w_tag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_xl   <= r_dly[RAMP-1][SMP_W-1:0];
            r_xr   <= r_dly[RAMP-1][2*SMP_W-1:SMP_W];
            r_xnum <= w_tnum[RAMP-1];
            r_xlen <= w_tlen[RAMP-1];
        end
        if (i_cmd.mul) begin
            r_negl <= w_pl[MAG_W];
            r_negr <= w_pr[MAG_W];
            r_ql   <= w_pl[MAG_W] ? MAG_W'(-w_pl) : MAG_W'(w_pl);
            r_qr   <= w_pr[MAG_W] ? MAG_W'(-w_pr) : MAG_W'(w_pr);
            r_reml <= '0;
            r_remr <= '0;
            r_dvs  <= w_mlen;
            r_cnt  <= '0;
        end
        if (i_cmd.step) begin
            r_reml <= w_dl[LEN_W+MAG_W-1:MAG_W];
            r_ql   <= w_dl[MAG_W-1:0];
            r_remr <= w_dr[LEN_W+MAG_W-1:MAG_W];
            r_qr   <= w_dr[MAG_W-1:0];
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.load) begin
            r_out.left_out       <= w_nl[SMP_W-1:0];
            r_out.right_out      <= w_nr[SMP_W-1:0];
            r_out.underrun_count <= r_under;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.div_last = (r_cnt == CNT_W'(MAG_W - 1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out             = r_out;
    assign o_out_valid       = r_out_valid;

endmodule

// ===== bench/testbench.sv =====
// testbench for the underrun tail fade pad: scoreboard with fade predictor and random stimulus
`timescale 1ns / 100ps

module testbench;
    import uttf_pkg::*;

    // fade predictor and the queue of expected output frames
    class fade_scoreboard;
        logic [31:0] line_q [RAMP];
        logic [5:0]  num_q [RAMP];
        logic [6:0]  len_q [RAMP];
        int unsigned slot_pos;
        int unsigned real_cnt;
        bit          short_flag;
        logic [31:0] underruns;
        bit          mono;
        t_out        frames_due [$];
        int          errors;
        int          checked;

        function new();
            for (int j = 0; j < RAMP; j++) begin
                line_q[j] = '0;
                num_q[j] = '0;
                len_q[j] = '0;
            end
            slot_pos = 0;
            real_cnt = 0;
            short_flag = 0;
            underruns = '0;
            mono = 0;
            errors = 0;
            checked = 0;
        endfunction

        function logic signed [15:0] scale(logic signed [15:0] s, logic [5:0] n, logic [6:0] l);
            int p;
            p = s;
            if (l != 0) begin
                p = (p * int'(n)) / int'(l);
            end
            return p[15:0];
        endfunction

        function void note_slot(t_in it);
            logic [15:0] l;
            logic [15:0] r;
            logic [31:0] frm;
            int unsigned ramp;
            t_out o;
            l = it.left_sample;
            r = mono ? l : it.right_sample;
            if (it.slot_present && !short_flag) begin
                frm = {r, l};
                real_cnt++;
            end else begin
                frm = '0;
                if (!short_flag) begin
                    ramp = (real_cnt < RAMP) ? real_cnt : RAMP;
                    short_flag = 1;
                    underruns++;
                    // newest entries get the tail tags, a new tag overwrites an old one
                    for (int j = 0; j < ramp; j++) begin
                        num_q[j] = 6'(j);
                        len_q[j] = 7'(ramp);
                    end
                end
            end
            o.left_out = scale(line_q[RAMP-1][15:0], num_q[RAMP-1], len_q[RAMP-1]);
            o.right_out = scale(line_q[RAMP-1][31:16], num_q[RAMP-1], len_q[RAMP-1]);
            o.underrun_count = underruns;
            frames_due.push_back(o);
            for (int j = RAMP - 1; j > 0; j--) begin
                line_q[j] = line_q[j-1];
                num_q[j] = num_q[j-1];
                len_q[j] = len_q[j-1];
            end
            line_q[0] = frm;
            num_q[0] = '0;
            len_q[0] = '0;
            slot_pos++;
            if (slot_pos >= FRAMES) begin
                slot_pos = 0;
                real_cnt = 0;
                short_flag = 0;
            end
        endfunction

        function void check_frame(t_out got);
            t_out w;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected output frame %h", $time, got);
                errors++;
                return;
            end
            w = frames_due.pop_front();
            checked++;
            if (got.left_out !== w.left_out) begin
                $display("%0t: left_out expected %h actual %h", $time, w.left_out, got.left_out);
                errors++;
            end
            if (got.right_out !== w.right_out) begin
                $display("%0t: right_out expected %h actual %h", $time, w.right_out,
                         got.right_out);
                errors++;
            end
            if (got.underrun_count !== w.underrun_count) begin
                $display("%0t: underrun_count expected %h actual %h", $time,
                         w.underrun_count, got.underrun_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    t_in  i_in;
    logic i_in_valid;
    logic o_in_stall;
    t_out o_out;
    logic o_out_valid;
    logic i_out_stall;

    fade_scoreboard sb;
    int unsigned sent;
    bit stall_on;

    underrun_tail_fade_pad dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out      (o_out),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // offer one slot and hold it until accepted; valid stays up when no gap follows
    task automatic send_slot(bit pres, logic [15:0] l, logic [15:0] r);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in <= '{slot_present: pres, left_sample: l, right_sample: r};
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_slot(i_in);
        sent++;
    endtask

    task automatic rand_slot(bit pres);
        send_slot(pres, 16'($urandom), 16'($urandom));
    endtask

    // wait until every expected frame is back, then idle with valid low
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.frames_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_mono(bit m);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.mono = m;
    endtask

    // output side: random stall, results checked on accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_frame(o_out);
            if (stall_on) i_out_stall <= ($urandom_range(0, 3) == 0);
            else i_out_stall <= 1'b0;
        end
    end

    // stall pattern changes now and then: long clear stretches, stretches of random stalls
    initial begin
        stall_on = 1;
        forever begin
            repeat ($urandom_range(50, 400)) @(posedge i_clk);
            stall_on = $urandom_range(0, 2) != 0;
        end
    end

    initial begin
        sb = new();
        sent = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_in = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes in stereo, then in mono
        set_mono(1'b0);
        send_slot(1, 16'h7fff, 16'h8000);
        send_slot(1, 16'h8000, 16'h7fff);
        send_slot(1, 16'hffff, 16'h0001);
        drain();
        set_mono(1'b1);
        send_slot(1, 16'h8000, 16'h1111);
        send_slot(1, 16'h7fff, 16'h2222);
        for (int k = 0; k < 8; k++) rand_slot(1);

        // random real runs under random mono settings, tail length depends on the total
        for (int b = 0; b < 3; b++) begin
            int run;
            drain();
            set_mono(1'($urandom_range(0, 1)));
            run = $urandom_range(10, 50);
            for (int k = 0; k < run; k++) rand_slot(1);
        end

        // first absent slot tags the tail, the rest is padding with stray present slots
        rand_slot(0);
        send_slot(1, 16'h7fff, 16'h7fff);
        while (sent < 500) rand_slot(1'($urandom_range(0, 1)));

        drain();
        $display("covered %0d slots with random gaps and output stalls, both mono settings",
                 sent);
        $display("one short buffer: %0d underrun, faded tail and padding over %0d frames",
                 sb.underruns, sb.checked);
        if (sb.errors == 0 && sb.frames_due.size() == 0) begin
            $display("underrun_tail_fade_pad test passed");
        end else begin
            $display("underrun_tail_fade_pad test failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("underrun_tail_fade_pad test failed");
        $finish;
    end
endmodule

// ===== underrun_tail_fade_pad.f =====
src/uttf_pkg.sv
src/uttf_ctrl.sv
src/uttf_dp.sv
src/underrun_tail_fade_pad.sv
bench/testbench.sv
